>>> sv/pafbf_pkg.sv
// Shared constants and types of the partition allocator.
package pafbf_pkg;

  localparam int unsigned MAX_PARTS_DEF = 32;
  localparam int unsigned ADDR_BITS_DEF = 16;

  localparam int unsigned OWNER_W = 16;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned PADDR_W = 16;
  localparam int unsigned CFG_W   = 16;

  localparam logic [LEN_W-1:0] RESET_MEMORY = 16'd640;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_NOOWNER = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic {
    FUNC_RELEASE  = 1'b0,
    FUNC_ALLOCATE = 1'b1
  } func_e;

  typedef enum logic {
    CFG_MEMORY_SIZE = 1'b0,
    CFG_FIT_MODE    = 1'b1
  } cfg_idx_e;

endpackage

>>> sv/pafbf_if.sv
// Request and response channel interfaces of the partition allocator.
interface pafbf_req_if import pafbf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [OWNER_W-1:0] owner_id;
  logic [LEN_W-1:0]   request_size;

  modport source (output valid, func, owner_id, request_size, input ready);
  modport sink   (input valid, func, owner_id, request_size, output ready);
endinterface

interface pafbf_rsp_if import pafbf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [PADDR_W-1:0] part_addr;
  logic [LEN_W-1:0]   part_len;

  modport source (output valid, status, part_addr, part_len, input ready);
  modport sink   (input valid, status, part_addr, part_len, output ready);
endinterface

>>> sv/partition_allocator_first_best_fit.sv
// Partition allocator top level: table memory, scan and shift sequencer.
//
// One request is handled at a time; ready is low while it is in work. A request
// scans the partition table through the single read port of the table memory,
// one entry a cycle (first fit stops at the first hit). A split moves every
// entry above the pick up by one and a release with merging moves the entries
// above it down, again one entry a cycle through the same port. A split then
// writes the two halves of the pick (S_INS_HI, S_INS_LO); a release reads its
// neighbours and writes the merged entry (S_RN, S_RP, S_MERGE) before it moves
// entries. A zero-size allocate answers without a scan. After reset, and after
// each write of the memory size register, the table is rebuilt as a single
// free partition before the next request is taken. The result sits in an
// output register, so it may wait for the sink while the block goes idle.
module partition_allocator_first_best_fit import pafbf_pkg::*; #(
  parameter int unsigned MAX_PARTS = MAX_PARTS_DEF,
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  pafbf_req_if.sink         req_i,
  pafbf_rsp_if.source       rsp_o
);

  localparam int unsigned IW = $clog2(MAX_PARTS);
  localparam int unsigned CW = $clog2(MAX_PARTS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PARTS);

  typedef struct packed {
    logic [ADDR_BITS-1:0] base;
    logic [LEN_W-1:0]     len;
    logic [OWNER_W-1:0]   owner;
    logic                 used;
  } entry_t;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SCAN   = 10'b0000000010,
    S_DECIDE = 10'b0000000100,
    S_RN     = 10'b0000001000,
    S_RP     = 10'b0000010000,
    S_MERGE  = 10'b0000100000,
    S_SHIFT  = 10'b0001000000,
    S_INS_HI = 10'b0010000000,
    S_INS_LO = 10'b0100000000,
    S_RESP   = 10'b1000000000
  } state_e;

  entry_t mem [MAX_PARTS];
  entry_t rdata_q;

  state_e             state_q;
  logic               init_q;
  logic [LEN_W-1:0]   memory_size_q;
  logic               fit_mode_q;
  logic [CW-1:0]      count_q;
  logic               op_alloc_q;
  logic [OWNER_W-1:0] owner_q;
  logic [LEN_W-1:0]   size_q;
  logic [CW-1:0]      scan_q;
  logic               chk_vld_q;
  logic [IW-1:0]      chk_idx_q;
  logic               stop_q;
  logic               found_q;
  logic [IW-1:0]      pick_q;
  entry_t             pick_ent_q;
  entry_t             nxt_ent_q;
  logic [CW-1:0]      src_q;
  logic               shift_up_q;
  logic [1:0]         shift_n_q;
  logic [CW-1:0]      lim_q;
  logic               pend_q;
  logic [IW-1:0]      pend_dst_q;
  status_e            res_st_q;
  logic [PADDR_W-1:0] res_addr_q;
  logic [LEN_W-1:0]   res_len_q;
  logic               out_vld_q;
  logic [1:0]         out_st_q;
  logic [PADDR_W-1:0] out_addr_q;
  logic [LEN_W-1:0]   out_len_q;

  logic               we;
  logic [IW-1:0]      waddr;
  entry_t             wdata;
  logic [IW-1:0]      raddr;

  logic               fits, hit, upd, stop_now, issue;
  logic               sh_issue;
  logic               has_next, has_prev;
  logic [LEN_W-1:0]   cur_len;
  logic [CW-1:0]      pick_c;

  assign pick_c   = CW'(pick_q);
  assign has_next = ((pick_c + CW'(1)) < count_q) && !nxt_ent_q.used;
  assign has_prev = (pick_q != '0) && !rdata_q.used;
  assign cur_len  = pick_ent_q.len + (has_next ? nxt_ent_q.len : LEN_W'(0));

  // Scan evaluation of the entry read in the previous cycle
  always_comb begin
    fits     = !rdata_q.used && (rdata_q.len >= size_q);
    hit      = rdata_q.used && (rdata_q.owner == owner_q);
    if (op_alloc_q) begin
      upd      = chk_vld_q && fits &&
                 (!found_q || (fit_mode_q && (rdata_q.len < pick_ent_q.len)));
      stop_now = chk_vld_q && fits && !fit_mode_q;
    end else begin
      upd      = chk_vld_q && hit && !found_q;
      stop_now = chk_vld_q && hit;
    end
    issue    = (scan_q < count_q) && !stop_q && !stop_now;
    sh_issue = shift_up_q ? (src_q > lim_q) : (src_q < count_q);
  end

  // Table memory port control
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    case (state_q)
      S_IDLE: begin
        if (init_q) begin
          we        = 1'b1;
          wdata.len = memory_size_q;
        end
      end
      S_SCAN:  raddr = scan_q[IW-1:0];
      S_DECIDE: begin
        if (op_alloc_q && found_q && (pick_ent_q.len == size_q)) begin
          we    = 1'b1;
          waddr = pick_q;
          wdata = '{base: pick_ent_q.base, len: size_q, owner: owner_q, used: 1'b1};
        end
      end
      S_RN:    raddr = pick_q + IW'(1);
      S_RP:    raddr = pick_q - IW'(1);
      S_MERGE: begin
        we = 1'b1;
        if (has_prev) begin
          waddr = pick_q - IW'(1);
          wdata = '{base: rdata_q.base, len: rdata_q.len + cur_len, owner: '0, used: 1'b0};
        end else begin
          waddr = pick_q;
          wdata = '{base: pick_ent_q.base, len: cur_len, owner: '0, used: 1'b0};
        end
      end
      S_SHIFT: begin
        raddr = src_q[IW-1:0];
        if (pend_q) begin
          we    = 1'b1;
          waddr = pend_dst_q;
          wdata = rdata_q;
        end
      end
      S_INS_HI: begin
        we    = 1'b1;
        waddr = pick_q + IW'(1);
        wdata = '{base: pick_ent_q.base + ADDR_BITS'(size_q),
                  len: pick_ent_q.len - size_q, owner: '0, used: 1'b0};
      end
      S_INS_LO: begin
        we    = 1'b1;
        waddr = pick_q;
        wdata = '{base: pick_ent_q.base, len: size_q, owner: owner_q, used: 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign req_i.ready     = (state_q == S_IDLE) && !init_q;
  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.status    = out_st_q;
  assign rsp_o.part_addr = out_addr_q;
  assign rsp_o.part_len  = out_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      init_q        <= 1'b1;
      memory_size_q <= RESET_MEMORY;
      fit_mode_q    <= 1'b0;
      count_q       <= CW'(1);
      op_alloc_q    <= 1'b0;
      owner_q       <= '0;
      size_q        <= '0;
      scan_q        <= '0;
      chk_vld_q     <= 1'b0;
      chk_idx_q     <= '0;
      stop_q        <= 1'b0;
      found_q       <= 1'b0;
      pick_q        <= '0;
      pick_ent_q    <= '0;
      nxt_ent_q     <= '0;
      src_q         <= '0;
      shift_up_q    <= 1'b0;
      shift_n_q     <= '0;
      lim_q         <= '0;
      pend_q        <= 1'b0;
      pend_dst_q    <= '0;
      res_st_q      <= ST_OK;
      res_addr_q    <= '0;
      res_len_q     <= '0;
      out_vld_q     <= 1'b0;
      out_st_q      <= '0;
      out_addr_q    <= '0;
      out_len_q     <= '0;
    end else begin
      if (out_vld_q && rsp_o.ready && (state_q != S_RESP)) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (init_q) begin
            count_q <= CW'(1);
          end else if (req_i.valid) begin
            op_alloc_q <= (req_i.func == FUNC_ALLOCATE);
            owner_q    <= req_i.owner_id;
            size_q     <= req_i.request_size;
            scan_q     <= '0;
            chk_vld_q  <= 1'b0;
            stop_q     <= 1'b0;
            found_q    <= 1'b0;
            if ((req_i.func == FUNC_ALLOCATE) && (req_i.request_size == '0)) begin
              res_st_q   <= ST_NOFIT;
              res_addr_q <= '0;
              res_len_q  <= '0;
              state_q    <= S_RESP;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (upd) begin
            found_q    <= 1'b1;
            pick_q     <= chk_idx_q;
            pick_ent_q <= rdata_q;
          end
          if (stop_now) begin
            stop_q <= 1'b1;
          end
          chk_vld_q <= issue;
          if (issue) begin
            scan_q    <= scan_q + CW'(1);
            chk_idx_q <= scan_q[IW-1:0];
          end else if (!chk_vld_q) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          res_addr_q <= '0;
          res_len_q  <= '0;
          if (!found_q) begin
            res_st_q <= op_alloc_q ? ST_NOFIT : ST_NOOWNER;
            state_q  <= S_RESP;
          end else if (!op_alloc_q) begin
            state_q <= S_RN;
          end else if (pick_ent_q.len == size_q) begin
            res_st_q   <= ST_OK;
            res_addr_q <= PADDR_W'(pick_ent_q.base);
            res_len_q  <= size_q;
            state_q    <= S_RESP;
          end else if (count_q >= CNT_MAX) begin
            res_st_q <= ST_FULL;
            state_q  <= S_RESP;
          end else begin
            // open a slot above the pick: move entries up, top first
            shift_up_q <= 1'b1;
            src_q      <= count_q - CW'(1);
            lim_q      <= pick_c;
            pend_q     <= 1'b0;
            state_q    <= S_SHIFT;
          end
        end
        S_RN: state_q <= S_RP;
        S_RP: begin
          nxt_ent_q <= rdata_q;
          state_q   <= S_MERGE;
        end
        S_MERGE: begin
          // close the gap left by merged neighbours: move entries down
          shift_up_q <= 1'b0;
          pend_q     <= 1'b0;
          if (has_prev) begin
            shift_n_q <= has_next ? 2'd2 : 2'd1;
            src_q     <= pick_c + (has_next ? CW'(2) : CW'(1));
          end else if (has_next) begin
            shift_n_q <= 2'd1;
            src_q     <= pick_c + CW'(2);
          end else begin
            shift_n_q <= 2'd0;
            src_q     <= count_q;
          end
          res_st_q   <= ST_OK;
          res_addr_q <= PADDR_W'(pick_ent_q.base);
          res_len_q  <= pick_ent_q.len;
          state_q    <= S_SHIFT;
        end
        S_SHIFT: begin
          pend_q <= sh_issue;
          if (sh_issue) begin
            if (shift_up_q) begin
              pend_dst_q <= src_q[IW-1:0] + IW'(1);
              src_q      <= src_q - CW'(1);
            end else begin
              pend_dst_q <= IW'(src_q - CW'(shift_n_q));
              src_q      <= src_q + CW'(1);
            end
          end else if (!pend_q) begin
            if (shift_up_q) begin
              state_q <= S_INS_HI;
            end else begin
              count_q <= count_q - CW'(shift_n_q);
              state_q <= S_RESP;
            end
          end
        end
        S_INS_HI: state_q <= S_INS_LO;
        S_INS_LO: begin
          count_q    <= count_q + CW'(1);
          res_st_q   <= ST_OK;
          res_addr_q <= PADDR_W'(pick_ent_q.base);
          res_len_q  <= size_q;
          state_q    <= S_RESP;
        end
        S_RESP: begin
          if (!out_vld_q || rsp_o.ready) begin
            out_vld_q  <= 1'b1;
            out_st_q   <= res_st_q;
            out_addr_q <= res_addr_q;
            out_len_q  <= res_len_q;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MEMORY_SIZE: memory_size_q <= cfg_data_i;
          CFG_FIT_MODE:    fit_mode_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
      // a memory size write rebuilds the table on the next idle cycle
      if (cfg_we_i && (cfg_idx_i == CFG_MEMORY_SIZE)) begin
        init_q <= 1'b1;
      end else if ((state_q == S_IDLE) && init_q) begin
        init_q <= 1'b0;
      end
    end
  end

endmodule

>>> test/tb_partition_allocator_first_best_fit.sv
// Self-checking testbench of the partition allocator: directed and random requests against a table predictor.
`timescale 1ns / 1ps
module tb_partition_allocator_first_best_fit;
  import pafbf_pkg::*;

  localparam int unsigned NPARTS = MAX_PARTS_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    func_e             func;
    logic [OWNER_W-1:0] owner;
    logic [LEN_W-1:0]   size;
  } request_t;

  typedef struct packed {
    status_e            status;
    logic [PADDR_W-1:0] addr;
    logic [LEN_W-1:0]   len;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  pafbf_req_if req_if ();
  pafbf_rsp_if rsp_if ();

  partition_allocator_first_best_fit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .req_i(req_if.sink), .rsp_o(rsp_if.source)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // predictor state
  logic [LEN_W-1:0]   tbl_base  [NPARTS];
  logic [LEN_W-1:0]   tbl_len   [NPARTS];
  logic [OWNER_W-1:0] tbl_owner [NPARTS];
  logic               tbl_used  [NPARTS];
  int                 tbl_count;
  logic [LEN_W-1:0]   mem_units;
  logic               fit_sel;

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  int       errors = 0;
  int       cycles = 0;
  bit       quiet_tail = 1'b0;
  bit       send_hold = 1'b0;

  function automatic void table_clear();
    for (int k = 0; k < NPARTS; k++) begin
      tbl_base[k] = '0; tbl_len[k] = '0; tbl_owner[k] = '0; tbl_used[k] = 1'b0;
    end
    tbl_len[0] = mem_units;
    tbl_count = 1;
  endfunction

  function automatic void drop_entry(int idx);
    for (int k = idx; k + 1 < tbl_count; k++) begin
      tbl_base[k] = tbl_base[k+1]; tbl_len[k] = tbl_len[k+1];
      tbl_owner[k] = tbl_owner[k+1]; tbl_used[k] = tbl_used[k+1];
    end
    if (tbl_count > 1) tbl_count--;
  endfunction

  function automatic answer_t predict_answer(request_t r);
    answer_t a;
    int pick;
    bit found;
    a = '{ST_OK, '0, '0};
    pick = 0;
    found = 1'b0;
    if (r.func == FUNC_ALLOCATE) begin
      if (r.size == 0) begin
        a.status = ST_NOFIT;
        return a;
      end
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_used[i] || tbl_len[i] < r.size) continue;
        if (!found) begin
          pick = i; found = 1'b1;
          if (!fit_sel) break;
        end else if (tbl_len[i] < tbl_len[pick]) begin
          pick = i;
        end
      end
      if (!found) begin
        a.status = ST_NOFIT;
        return a;
      end
      if (tbl_len[pick] > r.size) begin
        if (tbl_count >= NPARTS) begin
          a.status = ST_FULL;
          return a;
        end
        for (int k = tbl_count; k > pick + 1; k--) begin
          tbl_base[k] = tbl_base[k-1]; tbl_len[k] = tbl_len[k-1];
          tbl_owner[k] = tbl_owner[k-1]; tbl_used[k] = tbl_used[k-1];
        end
        tbl_base[pick+1] = tbl_base[pick] + r.size;
        tbl_len[pick+1] = tbl_len[pick] - r.size;
        tbl_owner[pick+1] = '0;
        tbl_used[pick+1] = 1'b0;
        tbl_len[pick] = r.size;
        tbl_count++;
      end
      tbl_used[pick] = 1'b1;
      tbl_owner[pick] = r.owner;
      a.addr = tbl_base[pick];
      a.len = tbl_len[pick];
    end else begin
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_used[i] && tbl_owner[i] == r.owner) begin
          pick = i; found = 1'b1;
          break;
        end
      end
      if (!found) begin
        a.status = ST_NOOWNER;
        return a;
      end
      a.addr = tbl_base[pick];
      a.len = tbl_len[pick];
      tbl_used[pick] = 1'b0;
      tbl_owner[pick] = '0;
      if (pick + 1 < tbl_count && !tbl_used[pick+1]) begin
        tbl_len[pick] = tbl_len[pick] + tbl_len[pick+1];
        drop_entry(pick + 1);
      end
      if (pick > 0 && !tbl_used[pick-1]) begin
        tbl_len[pick-1] = tbl_len[pick-1] + tbl_len[pick];
        drop_entry(pick);
      end
    end
    return a;
  endfunction

  // driver
  int send_gap = 0;
  initial begin
    req_if.valid = 1'b0;
    req_if.func = 1'b0;
    req_if.owner_id = '0;
    req_if.request_size = '0;
    rsp_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        expected_answers.push_back(predict_answer(request_t'({req_if.func, req_if.owner_id,
                                                              req_if.request_size})));
        void'(pending_reqs.pop_front());
      end
      if (req_if.valid && !req_if.ready) begin
        // hold the transaction until taken
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        req_if.valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0 && req_if.valid) begin
        send_gap <= $urandom_range(1, 15);
        req_if.valid <= 1'b0;
      end else if (pending_reqs.size() != 0 && !send_hold) begin
        request_t nx;
        nx = pending_reqs[0];
        req_if.valid <= 1'b1;
        req_if.func <= nx.func;
        req_if.owner_id <= nx.owner;
        req_if.request_size <= nx.size;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // monitor
  int recv_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (rsp_if.valid && rsp_if.ready) begin
        answer_t got;
        answer_t want;
        got = '{status_e'(rsp_if.status), rsp_if.part_addr, rsp_if.part_len};
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected answer %p", $time, got);
          errors++;
        end else begin
          want = expected_answers.pop_front();
          if (got.status !== want.status)
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          if (got.addr !== want.addr)
            $display("%0t: part_addr expected %0d actual %0d", $time, want.addr, got.addr);
          if (got.len !== want.len)
            $display("%0t: part_len expected %0d actual %0d", $time, want.len, got.len);
          if (got !== want) errors++;
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        rsp_if.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(1, 15);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic add_req(func_e f, int owner, int size);
    request_t r;
    r.func = f;
    r.owner = owner[OWNER_W-1:0];
    r.size = size[LEN_W-1:0];
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || req_if.valid) @(posedge clk_i);
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MEMORY_SIZE) begin
      mem_units = val[LEN_W-1:0];
      table_clear();
    end else begin
      fit_sel = val[0];
    end
    repeat (3) @(posedge clk_i);
  endtask

  // a phase of random alloc/release traffic, mostly from a pool of owners
  task automatic random_phase(int n, int max_size);
    for (int i = 0; i < n; i++) begin
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 9)
        add_req(FUNC_ALLOCATE, $urandom_range(0, 12), $urandom_range(1, max_size));
      else if (pick < 17)
        add_req(FUNC_RELEASE, $urandom_range(0, 12), $urandom);
      else if (pick == 17)
        add_req(FUNC_ALLOCATE, $urandom, $urandom);
      else if (pick == 18)
        add_req(FUNC_RELEASE, $urandom, $urandom);
      else
        add_req(FUNC_ALLOCATE, $urandom_range(0, 12), 0);
    end
    drain();
  endtask

  initial begin
    mem_units = RESET_MEMORY;
    fit_sel = 1'b0;
    table_clear();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed: zero size, exact fit, split, release merges, missing owner, extremes
    add_req(FUNC_ALLOCATE, 1, 0);
    add_req(FUNC_ALLOCATE, 16'hFFFF, 100);
    add_req(FUNC_ALLOCATE, 0, 200);
    add_req(FUNC_ALLOCATE, 5, 340);
    add_req(FUNC_ALLOCATE, 6, 1);
    add_req(FUNC_RELEASE, 0, 16'hFFFF);
    add_req(FUNC_RELEASE, 16'hFFFF, 0);
    add_req(FUNC_RELEASE, 5, 0);
    add_req(FUNC_RELEASE, 5, 0);
    add_req(FUNC_ALLOCATE, 7, 16'hFFFF);
    add_req(FUNC_ALLOCATE, 8, 640);
    add_req(FUNC_RELEASE, 8, 0);
    drain();
    write_reg(CFG_FIT_MODE, 1);
    add_req(FUNC_ALLOCATE, 1, 50);
    add_req(FUNC_ALLOCATE, 2, 10);
    add_req(FUNC_ALLOCATE, 3, 30);
    add_req(FUNC_ALLOCATE, 2, 10);
    add_req(FUNC_RELEASE, 2, 0);
    add_req(FUNC_RELEASE, 1, 0);
    add_req(FUNC_ALLOCATE, 4, 20);
    drain();
    // fill the table with 1-unit splits to hit table full
    write_reg(CFG_MEMORY_SIZE, 100);
    write_reg(CFG_FIT_MODE, 0);
    for (int i = 0; i < 33; i++) add_req(FUNC_ALLOCATE, i, 1);
    add_req(FUNC_ALLOCATE, 40, 68);
    drain();
    write_reg(CFG_MEMORY_SIZE, 0);
    add_req(FUNC_ALLOCATE, 1, 1);
    drain();
    write_reg(CFG_MEMORY_SIZE, 16'hFFFF);
    random_phase(120, 16'hFFFF);
    // pause the sender until every answer is in
    for (int i = 0; i < 8; i++) add_req(FUNC_ALLOCATE, 20 + i, 9);
    while (pending_reqs.size() > 4) @(posedge clk_i);
    send_hold = 1'b1;
    while (req_if.valid || expected_answers.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    send_hold = 1'b0;
    drain();
    write_reg(CFG_FIT_MODE, 1);
    write_reg(CFG_MEMORY_SIZE, 1);
    random_phase(30, 2);
    write_reg(CFG_MEMORY_SIZE, 300);
    random_phase(150, 40);
    write_reg(CFG_FIT_MODE, 0);
    random_phase(120, 30);
    quiet_tail = 1'b1;
    write_reg(CFG_FIT_MODE, 1);
    random_phase(80, 25);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

>>> partition_allocator_first_best_fit.f
sv/pafbf_pkg.sv
sv/pafbf_if.sv
sv/partition_allocator_first_best_fit.sv
test/tb_partition_allocator_first_best_fit.sv
